// ===== hw/rtl/hsc_pkg.sv =====
// ============================================================================
// hsc_pkg: shared types and constants for the 32-bit SECDED codec
// Parity masks, the bit-flip lookup and the pipeline stage bundles.
// ============================================================================
package hsc_pkg;

    localparam int unsigned DATA_W = 26;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CHK_W  = 6;
    localparam int unsigned SYN_W  = 5;

    // item commands
    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_CLEAN     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_DOUBLE    = 2'd2
    } status_t;

    // data masks for parity bits 5..1 (index 0 lands in bit 5)
    localparam logic [DATA_W-1:0] ENC_MASK [SYN_W] = '{
        26'h03fff80, 26'h1c7f878, 26'h2d9e666, 26'h36ad555, 26'h3b4b4cb
    };

    // codeword masks for check bits 5..0 (index 0 lands in bit 5)
    localparam logic [WORD_W-1:0] CHK_MASK [CHK_W] = '{
        32'hed2d32c2, 32'hdab55544, 32'hb6799988,
        32'h71fe1e10, 32'h0fffe020, 32'hffffffff
    };

    // syndrome to one-hot bit position
    localparam logic [WORD_W-1:0] FLIP_LUT [32] = '{
        32'h00000001,
        32'h00000020, 32'h00000010, 32'h00020000, 32'h00000008,
        32'h00008000, 32'h00000800, 32'h00400000, 32'h00000004,
        32'h00004000, 32'h00000400, 32'h00800000, 32'h00000100,
        32'h02000000, 32'h10000000, 32'h00100000, 32'h00000002,
        32'h00002000, 32'h00000200, 32'h01000000, 32'h00000080,
        32'h04000000, 32'h20000000, 32'h00080000, 32'h00000040,
        32'h08000000, 32'h40000000, 32'h00040000, 32'h80000000,
        32'h00010000, 32'h00001000, 32'h00200000
    };

    // stage 1: word with parity bits 5..1 filled, plus check bits for decode
    typedef struct packed {
        logic              valid;
        cmd_t              cmd;
        logic [WORD_W-1:0] word;
        logic [CHK_W-1:0]  chk;
    } s1_t;

    // stage 2: word and the mask to xor into it
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] mask;
        status_t           status;
    } s2_t;

endpackage

// ===== hw/rtl/hsc_check.sv =====
// ============================================================================
// hsc_check: first pipeline stage
// Encode: forms the five masked parity bits. Decode: forms the 6-bit check.
// ============================================================================
module hsc_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      cmd,
    input  logic [hsc_pkg::DATA_W-1:0] raw_data,
    input  logic [hsc_pkg::WORD_W-1:0] codeword_in,
    output hsc_pkg::s1_t              s1
);
    import hsc_pkg::*;

    s1_t s1_reg;
    s1_t s1_next;

    // parity trees, one per mask
    always_comb
    begin
        s1_next       = '0;
        s1_next.valid = accept;
        s1_next.cmd   = cmd_t'(cmd);
        if (cmd_t'(cmd) == CMD_ENCODE)
        begin
            s1_next.word = {raw_data, 6'b0};
            for (int i = 0; i < SYN_W; i++)
            begin
                s1_next.word[SYN_W-i] = ^(raw_data & ENC_MASK[i]);
            end
        end
        else
        begin
            s1_next.word = codeword_in;
            for (int i = 0; i < CHK_W; i++)
            begin
                s1_next.chk[CHK_W-1-i] = ^(codeword_in & CHK_MASK[i]);
            end
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ===== hw/rtl/hsc_locate.sv =====
// ============================================================================
// hsc_locate: second pipeline stage
// Picks the bit to flip (overall parity for encode, table bit for decode)
// and classifies the error.
// ============================================================================
module hsc_locate (
    input  logic         clk,
    input  logic         rst_n,
    input  hsc_pkg::s1_t s1,
    output hsc_pkg::s2_t s2
);
    import hsc_pkg::*;

    s2_t s2_reg;
    s2_t s2_next;

    // flip mask and status
    always_comb
    begin
        s2_next        = '0;
        s2_next.valid  = s1.valid;
        s2_next.word   = s1.word;
        s2_next.status = ST_CLEAN;
        priority if (s1.cmd == CMD_ENCODE)
        begin
            // overall parity of bits 31..1 goes into bit 0
            s2_next.mask[0] = ^s1.word[WORD_W-1:1];
        end
        else if (s1.chk[0])
        begin
            s2_next.mask   = FLIP_LUT[s1.chk[CHK_W-1:1]];
            s2_next.status = ST_CORRECTED;
        end
        else if (s1.chk[CHK_W-1:1] != '0)
        begin
            s2_next.status = ST_DOUBLE;
        end
        else
        begin
            // clean word
            s2_next.status = ST_CLEAN;
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== hw/rtl/hamming_secded_32_26_codec.sv =====
// ============================================================================
// hamming_secded_32_26_codec: 32-bit SECDED encoder / checker-corrector
// Throughput one item per cycle; start to done runs through the three register stages below.
// Three register stages (parity trees, flip lookup, xor and output); busy stays low.
// Reset (rst_n, async, active low) clears all valid bits; no item in flight.
// ============================================================================
module hamming_secded_32_26_codec (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cmd,
    input  logic [hsc_pkg::DATA_W-1:0] raw_data,
    input  logic [hsc_pkg::WORD_W-1:0] codeword_in,
    output logic                       done,
    output logic [hsc_pkg::WORD_W-1:0] codeword_out,
    output logic [hsc_pkg::DATA_W-1:0] data_out,
    output logic [1:0]                 status
);
    import hsc_pkg::*;

    s1_t               s1;
    s2_t               s2;
    logic              accept;
    logic              done_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    status_t           status_reg;

    // pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsc_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .raw_data    (raw_data),
        .codeword_in (codeword_in),
        .s1          (s1)
    );

    hsc_locate u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    // final stage: apply the flip
    assign word_next = s2.word ^ s2.mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        status_reg <= s2.status;
    end

    assign done         = done_reg;
    assign codeword_out = word_reg;
    assign data_out     = word_reg[WORD_W-1:WORD_W-DATA_W];
    assign status       = status_reg;

`ifndef SYNTH
    // every accepted item comes out as done after the three register stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("item lost in pipeline");

    // no result without an item accepted into the pipeline ahead of it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##3 !done)
        else $error("result without item");

    // every delivered word has even overall parity
    a_even_parity: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (^codeword_out) == 1'b0)
        else $error("output word has odd parity");

    // at most one bit is flipped
    a_single_flip: assert property (@(posedge clk) disable iff (!rst_n)
        s2.valid |-> $onehot0(s2.mask))
        else $error("flip mask not one-hot");
`endif

endmodule
